// ----- rtl/mpsa_pkg.sv -----
// Shared types and constants for the multi-pool slot allocator.
// Request/response payloads, status codes and the controller-datapath command set.
// No dependencies.
package mpsa_pkg;

  localparam int POOL_W = 3;   // pool number width on the ports
  localparam int SLOT_W = 6;   // slot number width on the ports
  localparam int WORD_W = 64;  // freed-map storage word
  localparam int BIT_W  = 6;   // bit index within a freed-map word

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // response status codes
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_FREED   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_NOPOOL  = 2'd3;

  // datapath actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_ALLOC_HW  = 4'd1;
  localparam logic [3:0] ACT_ALLOC_MAP = 4'd2;
  localparam logic [3:0] ACT_OPEN      = 4'd3;
  localparam logic [3:0] ACT_NOPOOL    = 4'd4;
  localparam logic [3:0] ACT_FREE_IGN  = 4'd5;
  localparam logic [3:0] ACT_FREE_TOP  = 4'd6;
  localparam logic [3:0] ACT_FREE_MAP  = 4'd7;
  localparam logic [3:0] ACT_SWAP1     = 4'd8;
  localparam logic [3:0] ACT_SWAP2     = 4'd9;

  // pool pointer sources
  localparam logic [2:0] PTR_HOLD = 3'd0;
  localparam logic [2:0] PTR_IN   = 3'd1;
  localparam logic [2:0] PTR_CUR  = 3'd2;
  localparam logic [2:0] PTR_ORD  = 3'd3;
  localparam logic [2:0] PTR_SEL  = 3'd4;

  // counter operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_CLR  = 2'd1;
  localparam logic [1:0] OP_INC  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [POOL_W-1:0] free_pool;
    logic [SLOT_W-1:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POOL_W-1:0] slot_pool;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] ptr_sel;
    logic [1:0] widx_op;
    logic [1:0] place_op;
    logic       sel_load;
    logic       req_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic can_open;
    logic has_freed;
    logic not_full;
    logic word_nz;
    logic place_last;
    logic free_ign;
    logic free_top;
  } sts_t;

  function automatic logic act_emits(input logic [3:0] act);
    logic r;
    case (act)
      ACT_ALLOC_HW, ACT_ALLOC_MAP, ACT_OPEN, ACT_NOPOOL,
      ACT_FREE_IGN, ACT_FREE_TOP, ACT_FREE_MAP: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mpsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mpsa_ctrl.sv -----
// Sequencing controller for the slot allocator: request intake, pool search,
// list swap and result hand-off. Depends on mpsa_pkg.
module mpsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mpsa_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  input  mpsa_pkg::sts_t sts,
  output mpsa_pkg::cmd_t cmd
);
  import mpsa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FREE = 4'd1;
  localparam logic [3:0] S_CUR  = 4'd2;
  localparam logic [3:0] S_WRC  = 4'd3;
  localparam logic [3:0] S_OPEN = 4'd4;
  localparam logic [3:0] S_SINF = 4'd5;
  localparam logic [3:0] S_SCHK = 4'd6;
  localparam logic [3:0] S_SWP1 = 4'd7;
  localparam logic [3:0] S_SWP2 = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       sel_ok_r, sel_ok_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    sel_ok_nxt   = sel_ok_r;
    cmd          = '0;
    cmd.act      = ACT_NONE;
    cmd.ptr_sel  = PTR_HOLD;
    cmd.widx_op  = OP_HOLD;
    cmd.place_op = OP_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          cmd.widx_op  = OP_CLR;
          if (in_req.req_type == REQ_FREE) begin
            cmd.ptr_sel = PTR_IN;
            state_nxt   = S_FREE;
          end else begin
            cmd.ptr_sel = PTR_CUR;
            state_nxt   = S_CUR;
          end
        end
      end
      S_FREE: begin
        if (out_free) begin
          if (sts.free_ign) begin
            cmd.act = ACT_FREE_IGN;
          end else if (sts.free_top) begin
            cmd.act = ACT_FREE_TOP;
          end else begin
            cmd.act = ACT_FREE_MAP;
          end
          state_nxt = S_IDLE;
        end
      end
      S_CUR: begin
        if (sts.cnt_zero) begin
          state_nxt = S_OPEN;
        end else if (!sts.has_freed && !sts.not_full) begin
          // current pool full: search the list
          cmd.place_op = OP_CLR;
          sel_ok_nxt   = 1'b0;
          state_nxt    = S_SINF;
        end else if (!sts.has_freed) begin
          if (out_free) begin
            cmd.act   = ACT_ALLOC_HW;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.widx_op = OP_CLR;
          state_nxt   = S_WRC;
        end
      end
      S_WRC: begin
        if (sts.word_nz) begin
          if (out_free) begin
            cmd.act   = ACT_ALLOC_MAP;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.widx_op = OP_INC;
        end
      end
      S_SINF: begin
        cmd.ptr_sel = PTR_ORD;
        state_nxt   = S_SCHK;
      end
      S_SCHK: begin
        if (sts.has_freed) begin
          cmd.sel_load = 1'b1;
          state_nxt    = S_SWP1;
        end else begin
          if (sts.not_full && !sel_ok_r) begin
            cmd.sel_load = 1'b1;
            sel_ok_nxt   = 1'b1;
          end
          if (sts.place_last) begin
            state_nxt = (sel_ok_r || sts.not_full) ? S_SWP1 : S_OPEN;
          end else begin
            cmd.place_op = OP_INC;
            state_nxt    = S_SINF;
          end
        end
      end
      S_SWP1: begin
        cmd.act   = ACT_SWAP1;
        state_nxt = S_SWP2;
      end
      S_SWP2: begin
        cmd.act     = ACT_SWAP2;
        cmd.ptr_sel = PTR_SEL;
        state_nxt   = S_CUR;
      end
      S_OPEN: begin
        if (out_free) begin
          cmd.act   = sts.can_open ? ACT_OPEN : ACT_NOPOOL;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = act_emits(cmd.act) || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sel_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sel_ok_r    <= sel_ok_nxt;
    end
  end

endmodule

// ----- rtl/mpsa_dpath.sv -----
// Datapath of the slot allocator: pool list, per-pool counts and freed maps
// in RAMs, pointers, and the result register. Depends on mpsa_pkg, mpsa_ram.
module mpsa_dpath #(
  parameter int POOL_SLOTS = 64,
  parameter int MAX_POOLS  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mpsa_pkg::req_t in_req,
  input  mpsa_pkg::cmd_t cmd,
  output mpsa_pkg::sts_t sts,
  output mpsa_pkg::rsp_t out_rsp
);
  import mpsa_pkg::*;

  localparam int HW_W      = $clog2(POOL_SLOTS + 1);
  localparam int PW        = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int CNT_W     = $clog2(MAX_POOLS + 1);
  localparam int MAP_WORDS = (POOL_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WB        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CMP_W     = (HW_W > SLOT_W) ? HW_W : SLOT_W;
  localparam int CP_W      = (CNT_W > POOL_W) ? CNT_W : POOL_W;

  req_t             req_r;
  rsp_t             rsp_r, rsp_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [WB-1:0]    widx_r, widx_nxt;
  logic [PW-1:0]    place_r, place_nxt;
  logic [PW-1:0]    sel_place_r, sel_pool_r;
  logic [PW-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [2*HW_W-1:0] info_rd, info_wd;
  logic [PW-1:0]     info_wa;
  logic              info_we;
  logic [WORD_W-1:0] word_rd, word_wd;
  logic [PW+WB-1:0]  word_wa;
  logic              word_we;
  logic [PW-1:0]     ord_rd, ord_wa, ord_wd;
  logic              ord_we;

  logic [HW_W-1:0]  hw_rd, fc_rd;
  logic [BIT_W-1:0] low_bit;
  logic [PW-1:0]    new_pool;
  logic [CMP_W-1:0] s_ext, hw_ext;
  logic             hw_at_word;

  assign hw_rd = info_rd[2*HW_W-1:HW_W];
  assign fc_rd = info_rd[HW_W-1:0];
  assign new_pool = PW'(count_r);

  always_comb begin
    case (cmd.ptr_sel)
      PTR_IN:  ptr_nxt = PW'(in_req.free_pool);
      PTR_CUR: ptr_nxt = cur_r;
      PTR_ORD: ptr_nxt = ord_rd;
      PTR_SEL: ptr_nxt = sel_pool_r;
      default: ptr_nxt = ptr_r;
    endcase
    case (cmd.widx_op)
      OP_CLR:  widx_nxt = '0;
      OP_INC:  widx_nxt = widx_r + WB'(1);
      default: widx_nxt = widx_r;
    endcase
    case (cmd.place_op)
      OP_CLR:  place_nxt = '0;
      OP_INC:  place_nxt = place_r + PW'(1);
      default: place_nxt = place_r;
    endcase
  end

  // lowest set bit of the freed word
  always_comb begin
    low_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word_rd[i]) begin
        low_bit = BIT_W'(i);
      end
    end
  end

  assign s_ext      = CMP_W'(req_r.free_slot);
  assign hw_ext     = CMP_W'(hw_rd);
  assign hw_at_word = (hw_rd & HW_W'(WORD_W - 1)) == '0;

  always_comb begin
    sts.cnt_zero   = (count_r == '0);
    sts.can_open   = (count_r < CNT_W'(MAX_POOLS));
    sts.has_freed  = (fc_rd != '0);
    sts.not_full   = (hw_rd < HW_W'(POOL_SLOTS));
    sts.word_nz    = (word_rd != '0);
    sts.place_last = ((CNT_W'(place_r) + CNT_W'(1)) == count_r);
    sts.free_ign   = (CP_W'(req_r.free_pool) >= CP_W'(count_r)) || (s_ext >= hw_ext) ||
                     word_rd[req_r.free_slot];
    sts.free_top   = ((s_ext + CMP_W'(1)) == hw_ext);
  end

  always_comb begin
    info_we   = 1'b0;
    info_wa   = ptr_r;
    info_wd   = info_rd;
    word_we   = 1'b0;
    word_wa   = {ptr_r, widx_r};
    word_wd   = '0;
    ord_we    = 1'b0;
    ord_wa    = sel_place_r;
    ord_wd    = cur_r;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    rsp_nxt   = rsp_r;
    case (cmd.act)
      ACT_ALLOC_HW: begin
        info_we = 1'b1;
        info_wa = cur_r;
        info_wd = {HW_W'(hw_rd + HW_W'(1)), fc_rd};
        // entering a fresh map word: clear it before any bit can be read
        word_we = hw_at_word;
        word_wa = {cur_r, WB'(hw_rd >> BIT_W)};
        rsp_nxt = '{status: ST_ALLOC, slot_pool: POOL_W'(cur_r), slot_index: SLOT_W'(hw_rd)};
      end
      ACT_ALLOC_MAP: begin
        info_we = 1'b1;
        info_wa = cur_r;
        info_wd = {hw_rd, HW_W'(fc_rd - HW_W'(1))};
        word_we = 1'b1;
        word_wa = {cur_r, widx_r};
        word_wd = word_rd & ~(WORD_W'(1) << low_bit);
        rsp_nxt = '{status: ST_ALLOC, slot_pool: POOL_W'(cur_r), slot_index: SLOT_W'(low_bit)};
      end
      ACT_OPEN: begin
        ord_we    = 1'b1;
        ord_wa    = new_pool;
        ord_wd    = new_pool;
        info_we   = 1'b1;
        info_wa   = new_pool;
        info_wd   = {HW_W'(1), HW_W'(0)};
        word_we   = 1'b1;
        word_wa   = {new_pool, WB'(0)};
        cur_nxt   = new_pool;
        count_nxt = count_r + CNT_W'(1);
        rsp_nxt   = '{status: ST_ALLOC, slot_pool: POOL_W'(new_pool), slot_index: '0};
      end
      ACT_NOPOOL: begin
        rsp_nxt = '{status: ST_NOPOOL, slot_pool: '0, slot_index: '0};
      end
      ACT_FREE_IGN: begin
        rsp_nxt = '{status: ST_IGNORED, slot_pool: '0, slot_index: '0};
      end
      ACT_FREE_TOP: begin
        info_we = 1'b1;
        info_wd = {HW_W'(hw_rd - HW_W'(1)), fc_rd};
        rsp_nxt = '{status: ST_FREED, slot_pool: '0, slot_index: '0};
      end
      ACT_FREE_MAP: begin
        info_we = 1'b1;
        info_wd = {hw_rd, HW_W'(fc_rd + HW_W'(1))};
        word_we = 1'b1;
        word_wd = word_rd | (WORD_W'(1) << req_r.free_slot);
        rsp_nxt = '{status: ST_FREED, slot_pool: '0, slot_index: '0};
      end
      ACT_SWAP1: begin
        ord_we = 1'b1;
      end
      ACT_SWAP2: begin
        ord_we  = 1'b1;
        ord_wa  = PW'(count_r - CNT_W'(1));
        ord_wd  = sel_pool_r;
        cur_nxt = sel_pool_r;
      end
      default: begin
      end
    endcase
  end

  mpsa_ram #(.WIDTH(2 * HW_W), .DEPTH(MAX_POOLS)) u_info (
    .clk(clk), .we(info_we), .waddr(info_wa), .wdata(info_wd),
    .raddr(ptr_nxt), .rdata(info_rd)
  );

  mpsa_ram #(.WIDTH(WORD_W), .DEPTH(2 ** (PW + WB))) u_map (
    .clk(clk), .we(word_we), .waddr(word_wa), .wdata(word_wd),
    .raddr({ptr_nxt, widx_nxt}), .rdata(word_rd)
  );

  mpsa_ram #(.WIDTH(PW), .DEPTH(MAX_POOLS)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .raddr(place_nxt), .rdata(ord_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_req;
    end
    if (cmd.sel_load) begin
      sel_place_r <= place_r;
      sel_pool_r  <= ptr_r;
    end
    ptr_r   <= ptr_nxt;
    widx_r  <= widx_nxt;
    place_r <= place_nxt;
    cur_r   <= cur_nxt;
    rsp_r   <= rsp_nxt;
  end

  assign out_rsp = rsp_r;

endmodule

// ----- rtl/multi_pool_slot_allocator.sv -----
// Multi-pool slot allocator, top level: controller plus datapath.
// Flow: a request is taken in the idle state; a free, or an allocate served by the current pool's
// high-water mark, registers its result from the free-check or current-pool state once the output
// register is free; reusing a freed slot first walks the freed-map words, and a full current pool
// first scans the list place by place, then swaps a pool in or opens one or refuses. One request at a time.
// Reset: synchronous, active low; empties the pool list and clears the output valid flag, no clearing pass.
module multi_pool_slot_allocator #(
  parameter int POOL_SLOTS = 64,
  parameter int MAX_POOLS  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mpsa_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output mpsa_pkg::rsp_t out_rsp
);
  import mpsa_pkg::*;

  // The controller walks each request through its states and only issues a
  // result-producing action when the output register is free or being drained,
  // so a waiting result never blocks the next request from being taken.
  cmd_t cmd;
  sts_t sts;

  // Sequencing: intake, free check, current-pool allocate, freed-map word
  // walk, list search (a read state and a check state per place), swap into
  // the current place and pool opening.
  mpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage: the pool list order, each pool's high-water and freed counts,
  // and the freed maps word by word. Pools are numbered in opening order,
  // so the open-pool count marks which entries hold live data; a pool's
  // entries are written as it opens, and each map word is cleared as the
  // high-water mark first reaches it.
  mpsa_dpath #(
    .POOL_SLOTS (POOL_SLOTS),
    .MAX_POOLS  (MAX_POOLS)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

endmodule
